// ===== sv/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper with real time clock.
package cbm_pkg;

  localparam int unsigned RAM_BANKS     = 4;
  localparam int unsigned ROM_ADDR_BITS = 22;
  localparam int unsigned ROM_W         = 22;
  localparam int unsigned BANK_OFS_W    = 13;
  localparam int unsigned BANK_SEL_W    = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
  localparam int unsigned RAM_AW        = BANK_OFS_W + BANK_SEL_W;
  localparam int unsigned RAM_DEPTH     = RAM_BANKS * (2 ** BANK_OFS_W);
  localparam int unsigned CFG_W         = 22;

  localparam logic [ROM_W-1:0] ROM_MASK  = ROM_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);
  localparam logic [ROM_W-1:0] BANK1_BASE = ROM_W'(32'h4000);

  // Bus address regions, addr[15:13]
  localparam logic [2:0] REG_RAM_EN   = 3'd0;
  localparam logic [2:0] REG_ROM_BANK = 3'd1;
  localparam logic [2:0] REG_RAM_BANK = 3'd2;
  localparam logic [2:0] REG_LATCH    = 3'd3;
  localparam logic [2:0] WIN_EXT      = 3'd5;

  // Clock register selections
  localparam logic [3:0] CLK_SEL_FIRST = 4'd8;
  localparam logic [3:0] CLK_SEL_LAST  = 4'd12;
  localparam logic [2:0] CLK_SEC       = 3'd0;
  localparam logic [2:0] CLK_MIN       = 3'd1;
  localparam logic [2:0] CLK_HRS       = 3'd2;
  localparam logic [2:0] CLK_DAY_LO    = 3'd3;

  localparam logic [7:0] RD_IDLE = 8'hff;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2
  } cbm_action_e;

  typedef enum logic [1:0] {
    CFG_ROM_SIZE_MASK = 2'd0,
    CFG_RAM_ADDR_MASK = 2'd1,
    CFG_RAM_PRESENT   = 2'd2,
    CFG_RTC_PRESENT   = 2'd3
  } cbm_cfg_idx_e;

  // Response of the register block for one transaction
  typedef struct packed {
    logic [7:0]       rdata;
    logic [ROM_W-1:0] rom_addr;
    logic             rom_access;
    logic             ram_rd;
    logic             ram_wr;
    logic [RAM_AW-1:0] ram_addr;
  } cbm_rsp_t;

  function automatic logic [7:0] clock_mask(input logic [2:0] sel);
    logic [7:0] m;
    case (sel)
      CLK_SEC:    m = 8'h3f;
      CLK_MIN:    m = 8'h3f;
      CLK_HRS:    m = 8'h1f;
      CLK_DAY_LO: m = 8'hff;
      default:    m = 8'hc1;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/cbm_in_if.sv =====
// Input channel: bus reads, bus writes and one-second ticks.
interface cbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [15:0] addr;
  logic [7:0] wdata;

  modport source (output valid, output action, output addr, output wdata, input ready);
  modport sink   (input valid, input action, input addr, input wdata, output ready);
endinterface

// ===== sv/cbm_out_if.sv =====
// Output channel: read data and translated ROM address.
interface cbm_out_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               rdata;
  logic [cbm_pkg::ROM_W-1:0] rom_addr;
  logic                     rom_access;

  modport source (output valid, output rdata, output rom_addr, output rom_access, input ready);
  modport sink   (input valid, input rdata, input rom_addr, input rom_access, output ready);
endinterface

// ===== sv/cbm_ram.sv =====
// Generic single-port RAM with registered read.
module cbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cbm_regs.sv =====
// Control registers, real time clock and access decode.
module cbm_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [cbm_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      acc_i,
  input  logic [1:0]                action_i,
  input  logic [15:0]               addr_i,
  input  logic [7:0]                wdata_i,
  output cbm_pkg::cbm_rsp_t         rsp_o
);

  logic [cbm_pkg::ROM_W-1:0] rom_mask_q;
  logic [12:0]               ram_mask_q;
  logic                      ram_present_q, rtc_present_q;

  logic                      ram_en_q, ram_en_d;
  logic [cbm_pkg::ROM_W-1:0] rom_base_q, rom_base_d;
  logic [3:0]                ram_bank_q, ram_bank_d;
  logic                      latch_q, latch_d;
  logic [5:0]                sec_q, sec_d, min_q, min_d;
  logic [4:0]                hrs_q, hrs_d;
  logic [7:0]                day_lo_q, day_lo_d, day_hi_q, day_hi_d;
  logic [7:0]                lat_q [5];
  logic [7:0]                lat_d [5];
  logic [7:0]                live [5];

  logic [2:0]                region;
  logic                      bank_is_ram, bank_is_clk;
  logic [2:0]                clk_sel;
  logic [cbm_pkg::ROM_W-1:0] rom_sum, new_base;
  logic [5:0]                sec_inc, min_inc;
  logic [4:0]                hrs_inc;
  logic [7:0]                hi_inc;
  logic                      is_rd, is_wr, is_tick;

  assign region      = addr_i[15:13];
  assign bank_is_ram = (ram_bank_q < 4'(cbm_pkg::RAM_BANKS));
  assign bank_is_clk = rtc_present_q && (ram_bank_q >= cbm_pkg::CLK_SEL_FIRST)
                       && (ram_bank_q <= cbm_pkg::CLK_SEL_LAST);
  assign clk_sel     = 3'(ram_bank_q - cbm_pkg::CLK_SEL_FIRST);
  assign is_rd       = (action_i == cbm_pkg::ACT_READ);
  assign is_wr       = (action_i == cbm_pkg::ACT_WRITE);
  assign is_tick     = (action_i == cbm_pkg::ACT_TICK);

  assign live[0] = {2'b00, sec_q};
  assign live[1] = {2'b00, min_q};
  assign live[2] = {3'b000, hrs_q};
  assign live[3] = day_lo_q;
  assign live[4] = day_hi_q;

  assign rom_sum  = rom_base_q + {8'd0, addr_i[13:0]};
  assign new_base = ((wdata_i == 8'd0) ? cbm_pkg::BANK1_BASE : {wdata_i, 14'd0})
                    & rom_mask_q & cbm_pkg::ROM_MASK;
  assign sec_inc  = sec_q + 6'd1;
  assign min_inc  = min_q + 6'd1;
  assign hrs_inc  = hrs_q + 5'd1;
  assign hi_inc   = day_hi_q + 8'd1;

  // Response decode
  always_comb begin
    rsp_o = '0;
    rsp_o.rdata    = cbm_pkg::RD_IDLE;
    rsp_o.ram_addr = {ram_bank_q[cbm_pkg::BANK_SEL_W-1:0], addr_i[12:0] & ram_mask_q};
    if (is_rd) begin
      if (!addr_i[15]) begin
        rsp_o.rom_access = 1'b1;
        rsp_o.rom_addr   = (addr_i[14] ? rom_sum : {8'd0, addr_i[13:0]})
                           & rom_mask_q & cbm_pkg::ROM_MASK;
      end else if (region == cbm_pkg::WIN_EXT && ram_en_q) begin
        if (bank_is_ram) begin
          rsp_o.ram_rd = 1'b1;
        end else if (bank_is_clk) begin
          rsp_o.rdata = (latch_q ? lat_q[clk_sel] : live[clk_sel])
                        & cbm_pkg::clock_mask(clk_sel);
        end
      end
    end
    rsp_o.ram_wr = is_wr && region == cbm_pkg::WIN_EXT && ram_en_q && bank_is_ram;
    if (!acc_i) begin
      rsp_o.ram_rd = 1'b0;
      rsp_o.ram_wr = 1'b0;
    end
  end

  // State update
  always_comb begin
    ram_en_d   = ram_en_q;
    rom_base_d = rom_base_q;
    ram_bank_d = ram_bank_q;
    latch_d    = latch_q;
    sec_d      = sec_q;
    min_d      = min_q;
    hrs_d      = hrs_q;
    day_lo_d   = day_lo_q;
    day_hi_d   = day_hi_q;
    lat_d      = lat_q;
    if (acc_i && is_wr) begin
      case (region)
        cbm_pkg::REG_RAM_EN: begin
          if (ram_present_q) ram_en_d = (wdata_i[3:0] == 4'ha);
        end
        cbm_pkg::REG_ROM_BANK: rom_base_d = new_base;
        cbm_pkg::REG_RAM_BANK: ram_bank_d = wdata_i[3:0];
        cbm_pkg::REG_LATCH: begin
          if (rtc_present_q) begin
            if (!latch_q && wdata_i[0]) lat_d = live;
            latch_d = wdata_i[0];
          end
        end
        cbm_pkg::WIN_EXT: begin
          if (ram_en_q && !bank_is_ram && bank_is_clk) begin
            case (clk_sel)
              cbm_pkg::CLK_SEC:    sec_d    = wdata_i[5:0];
              cbm_pkg::CLK_MIN:    min_d    = wdata_i[5:0];
              cbm_pkg::CLK_HRS:    hrs_d    = wdata_i[4:0];
              cbm_pkg::CLK_DAY_LO: day_lo_d = wdata_i;
              default:             day_hi_d = wdata_i;
            endcase
          end
        end
        default: ;
      endcase
    end else if (acc_i && is_tick && rtc_present_q && !day_hi_q[6]) begin
      sec_d = sec_inc;
      if (sec_inc == 6'd60) begin
        sec_d = '0;
        min_d = min_inc;
        if (min_inc == 6'd60) begin
          min_d = '0;
          hrs_d = hrs_inc;
          if (hrs_inc == 5'd24) begin
            hrs_d    = '0;
            day_lo_d = day_lo_q + 8'd1;
            if (day_lo_q == 8'hff) begin
              // carry out of bit 8 sets the overflow flag
              day_hi_d = hi_inc[1] ? ((hi_inc & 8'hfd) | 8'h80) : hi_inc;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_mask_q    <= cbm_pkg::ROM_MASK;
      ram_mask_q    <= 13'h1fff;
      ram_present_q <= 1'b1;
      rtc_present_q <= 1'b1;
      ram_en_q      <= 1'b0;
      rom_base_q    <= cbm_pkg::BANK1_BASE;
      ram_bank_q    <= '0;
      latch_q       <= 1'b0;
      sec_q         <= '0;
      min_q         <= '0;
      hrs_q         <= '0;
      day_lo_q      <= '0;
      day_hi_q      <= '0;
      for (int i = 0; i < 5; i++) lat_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cbm_pkg::CFG_ROM_SIZE_MASK: rom_mask_q    <= cfg_wdata_i[cbm_pkg::ROM_W-1:0];
          cbm_pkg::CFG_RAM_ADDR_MASK: ram_mask_q    <= cfg_wdata_i[12:0];
          cbm_pkg::CFG_RAM_PRESENT:   ram_present_q <= cfg_wdata_i[0];
          default:                    rtc_present_q <= cfg_wdata_i[0];
        endcase
      end
      ram_en_q   <= ram_en_d;
      rom_base_q <= rom_base_d;
      ram_bank_q <= ram_bank_d;
      latch_q    <= latch_d;
      sec_q      <= sec_d;
      min_q      <= min_d;
      hrs_q      <= hrs_d;
      day_lo_q   <= day_lo_d;
      day_hi_q   <= day_hi_d;
      lat_q      <= lat_d;
    end
  end

endmodule

// ===== sv/cbm_out_stage.sv =====
// Read-return stage and output register; merges RAM read data into the result.
module cbm_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  cbm_pkg::cbm_rsp_t         rsp_i,
  input  logic [7:0]                ram_rdata_i,
  output logic                      in_ready_o,
  cbm_out_if.source                 out_if
);

  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_fresh_q;
  logic                      s1_ram_q;
  logic [7:0]                s1_rdata_q;
  logic [cbm_pkg::ROM_W-1:0] s1_rom_addr_q;
  logic                      s1_rom_acc_q;
  logic [7:0]                s1_rdata;

  logic                      o_valid_q, o_valid_d;
  logic [7:0]                o_rdata_q;
  logic [cbm_pkg::ROM_W-1:0] o_rom_addr_q;
  logic                      o_rom_acc_q;
  logic                      s1_move;

  // RAM read data is taken from the RAM port only in the cycle after the read
  assign s1_rdata   = (s1_ram_q && s1_fresh_q) ? ram_rdata_i : s1_rdata_q;
  assign s1_move    = s1_valid_q && (!o_valid_q || out_if.ready);
  assign in_ready_o = !s1_valid_q || !o_valid_q || out_if.ready;
  assign s1_valid_d = acc_i || (s1_valid_q && !s1_move);
  assign o_valid_d  = s1_move || (o_valid_q && !out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fresh_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_fresh_q <= acc_i;
      o_valid_q  <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_ram_q      <= rsp_i.ram_rd;
      s1_rdata_q    <= rsp_i.rdata;
      s1_rom_addr_q <= rsp_i.rom_addr;
      s1_rom_acc_q  <= rsp_i.rom_access;
    end else if (s1_valid_q) begin
      s1_rdata_q <= s1_rdata;
      s1_ram_q   <= 1'b0;
    end
    if (s1_move) begin
      o_rdata_q    <= s1_rdata;
      o_rom_addr_q <= s1_rom_addr_q;
      o_rom_acc_q  <= s1_rom_acc_q;
    end
  end

  assign out_if.valid      = o_valid_q;
  assign out_if.rdata      = o_rdata_q;
  assign out_if.rom_addr   = o_rom_addr_q;
  assign out_if.rom_access = o_rom_acc_q;

endmodule

// ===== sv/cartridge_bank_mapper_with_rtc_core.sv =====
// Top level of the cartridge bank mapper with real time clock.
// A transaction is registered in the read-return stage, then in the output register.
// Throughput: one transaction per cycle unless the output stalls; the single RAM port takes
// one access each cycle. A waiting result stalls input once the read-return stage is full.
// Reset: asynchronous, active low; clears control, clock and latch state; RAM is not cleared.
module cartridge_bank_mapper_with_rtc_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [cbm_pkg::CFG_W-1:0] cfg_wdata_i,
  cbm_in_if.sink                    in_if,
  cbm_out_if.source                 out_if
);

  cbm_pkg::cbm_rsp_t rsp;
  logic              acc;
  logic              in_ready;
  logic [7:0]        ram_rdata;

  assign in_if.ready = in_ready;
  assign acc         = in_if.valid && in_ready;

  cbm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .action_i    (in_if.action),
    .addr_i      (in_if.addr),
    .wdata_i     (in_if.wdata),
    .rsp_o       (rsp)
  );

  cbm_ram #(
    .WIDTH (8),
    .DEPTH (cbm_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (rsp.ram_wr),
    .re_i    (rsp.ram_rd),
    .addr_i  (rsp.ram_addr[$clog2(cbm_pkg::RAM_DEPTH)-1:0]),
    .wdata_i (in_if.wdata),
    .rdata_o (ram_rdata)
  );

  cbm_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .rsp_i       (rsp),
    .ram_rdata_i (ram_rdata),
    .in_ready_o  (in_ready),
    .out_if      (out_if)
  );

endmodule

// ===== sv/cbm_checker.sv =====
// Port-level assertions for the mapper top level, with bind.
module cbm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [7:0]                out_rdata_i,
  input logic [cbm_pkg::ROM_W-1:0] out_rom_addr_i,
  input logic                      out_rom_access_i
);

  // ROM reads return no byte
  a_rom_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rom_access_i |-> out_rdata_i == 8'hff)
    else $error("ROM result carries read data");

  // translated address only on ROM reads
  a_rom_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_rom_access_i |-> out_rom_addr_i == '0)
    else $error("ROM address without ROM access");

  // empty output register never stalls input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output empty");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rdata_i)
    && $stable(out_rom_addr_i) && $stable(out_rom_access_i))
    else $error("stalled result changed");

endmodule

bind cartridge_bank_mapper_with_rtc_core cbm_checker u_cbm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_rdata_i      (out_if.rdata),
  .out_rom_addr_i   (out_if.rom_addr),
  .out_rom_access_i (out_if.rom_access)
);
